// ----- hdl/bsf_pkg.sv -----
// Shared types, widths and codes for the baseline shadow flagger.
// No dependencies; imported by every module of the block except bsf_ram.
package bsf_pkg;

   localparam int NUM_ANTENNAS = 256;

   localparam int MODE_W  = 2;
   localparam int ANT_W   = 8;
   localparam int COORD_W = 31;
   localparam int DIAM_W  = 20;
   localparam int TOL_W   = 21;

   // Only antennas reachable by an 8-bit index need a table entry.
   localparam int TABLE_DEPTH = (NUM_ANTENNAS < (1 << ANT_W)) ? NUM_ANTENNAS : (1 << ANT_W);
   localparam int ANT_ADDR_W  = $clog2(TABLE_DEPTH);

   // Shadow test widths: magnitude, square, 4*(u^2+v^2), limit, limit squared.
   localparam int MAG_W = COORD_W;
   localparam int SQ_W  = 2 * MAG_W;
   localparam int UV4_W = SQ_W + 3;
   localparam int LIM_W = DIAM_W + 4;
   localparam int LSQ_W = 2 * (LIM_W - 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ROW   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_ROW,
      OP_QUERY
   } op_type;

   // One classified beat as it sits in the queue.
   typedef struct packed {
      op_type                op;
      logic                  clear;     // row: wipe the bitmap first
      logic                  row_live;  // row: valid pair, not an autocorrelation
      logic                  ok1;
      logic                  ok2;
      logic [ANT_ADDR_W-1:0] addr1;
      logic [ANT_ADDR_W-1:0] addr2;
      logic [MAG_W-1:0]      u_mag;
      logic [MAG_W-1:0]      v_mag;
      logic                  w_pos;
      logic [DIAM_W-1:0]     diameter;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// ----- hdl/bsf_ram.sv -----
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module bsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ----- hdl/bsf_front.sv -----
// Front end: takes request beats, drops ones with no effect, classifies the rest.
// Depends on bsf_pkg.
module bsf_front import bsf_pkg::*; (
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic                req_new_timestep,
   input  logic [ANT_W-1:0]    req_first_antenna,
   input  logic [ANT_W-1:0]    req_second_antenna,
   input  logic [COORD_W-1:0]  req_u_component,
   input  logic [COORD_W-1:0]  req_v_component,
   input  logic [COORD_W-1:0]  req_w_component,
   input  logic [DIAM_W-1:0]   req_dish_diameter,
   input  queue_status_type    queue_status,
   output logic                push,
   output item_type            push_item
);

   logic ok1, ok2, keep;

   assign ok1 = ({24'd0, req_first_antenna} < 32'(NUM_ANTENNAS));
   assign ok2 = ({24'd0, req_second_antenna} < 32'(NUM_ANTENNAS));

   always_comb begin
      push_item          = '0;
      keep               = 1'b0;
      push_item.ok1      = ok1;
      push_item.ok2      = ok2;
      push_item.addr1    = req_first_antenna[ANT_ADDR_W-1:0];
      push_item.addr2    = req_second_antenna[ANT_ADDR_W-1:0];
      push_item.u_mag    = req_u_component[COORD_W-1] ? (~req_u_component + 1'b1)
                                                      : req_u_component;
      push_item.v_mag    = req_v_component[COORD_W-1] ? (~req_v_component + 1'b1)
                                                      : req_v_component;
      push_item.w_pos    = !req_w_component[COORD_W-1] && (req_w_component != '0);
      push_item.diameter = req_dish_diameter;
      case (req_mode)
         MODE_LOAD: begin
            push_item.op = OP_LOAD;
            keep         = ok1;
         end
         MODE_ROW: begin
            push_item.op       = OP_ROW;
            push_item.clear    = req_new_timestep;
            push_item.row_live = ok1 && ok2 && (req_first_antenna != req_second_antenna);
            keep               = 1'b1;
         end
         MODE_QUERY: begin
            push_item.op = OP_QUERY;
            keep         = 1'b1;
         end
         default: begin
            push_item.op = OP_LOAD;   // unused mode: beat taken and dropped
            keep         = 1'b0;
         end
      endcase
   end

   assign req_stall = queue_status.full;
   assign push      = req_valid && !queue_status.full && keep;

endmodule

// ----- hdl/bsf_queue.sv -----
// Short queue of classified beats between front and back end.
// Depends on bsf_pkg.
module bsf_queue import bsf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         head_item,
   output queue_status_type queue_status
);

   item_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] ptr);
      if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item          = entries_ff[rd_ptr_ff];
   assign queue_status.empty = (count_ff == '0);
   assign queue_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));

endmodule

// ----- hdl/bsf_back.sv -----
// Back end: executes loads, baseline rows and queries; owns the shadow bitmap,
// the diameter table and the response register. Depends on bsf_pkg, bsf_ram.
module bsf_back import bsf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [TOL_W-1:0]  tolerance,
   input  item_type          head_item,
   input  queue_status_type  queue_status,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_row_flag,
   output logic              rsp_first_shadowed,
   output logic              rsp_second_shadowed
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LIMIT,
      ST_SQUARE,
      ST_DECIDE
   } state_type;

   state_type               state_ff, state_in;
   item_type                item_ff, item_in;
   logic [TABLE_DEPTH-1:0]  shadow_ff, shadow_in;
   logic signed [LIM_W-1:0] lim_ff, lim_in;
   logic [SQ_W-1:0]         u_sq_ff, u_sq_in;
   logic [SQ_W-1:0]         v_sq_ff, v_sq_in;
   logic [LSQ_W-1:0]        lsq_ff, lsq_in;
   logic                    lim_pos_ff, lim_pos_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_first_ff, rsp_first_in;
   logic                    rsp_second_ff, rsp_second_in;

   logic                    ram_we;
   logic [DIAM_W-1:0]       diam1, diam2;
   logic                    out_free;
   logic [UV4_W-1:0]        uv4;
   logic                    f1, f2;

   bsf_ram #(
      .WIDTH (DIAM_W),
      .DEPTH (TABLE_DEPTH)
   ) u_diam_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (head_item.addr1),
      .wr_data   (head_item.diameter),
      .rd_addr_a (head_item.addr1),
      .rd_addr_b (head_item.addr2),
      .rd_data_a (diam1),
      .rd_data_b (diam2)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign uv4      = {({1'b0, u_sq_ff} + {1'b0, v_sq_ff}), 2'b00};
   assign f1       = head_item.ok1 && shadow_ff[head_item.addr1];
   assign f2       = head_item.ok2 && shadow_ff[head_item.addr2];

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      shadow_in     = shadow_ff;
      lim_in        = lim_ff;
      u_sq_in       = u_sq_ff;
      v_sq_in       = v_sq_ff;
      lsq_in        = lsq_ff;
      lim_pos_in    = lim_pos_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      pop           = 1'b0;
      ram_we        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!queue_status.empty) begin
               case (head_item.op)
                  OP_LOAD: begin
                     pop    = 1'b1;
                     ram_we = 1'b1;
                  end
                  OP_ROW: begin
                     pop     = 1'b1;
                     item_in = head_item;
                     if (head_item.clear) begin
                        shadow_in = '0;
                     end
                     // table read issues this cycle from the head addresses
                     if (head_item.row_live) begin
                        state_in = ST_LIMIT;
                     end
                  end
                  OP_QUERY: begin
                     if (out_free) begin
                        pop           = 1'b1;
                        rsp_valid_in  = 1'b1;
                        rsp_first_in  = f1;
                        rsp_second_in = f2;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_LIMIT: begin
            // S = d1 + d2 - 2*tolerance
            lim_in   = $signed({4'd0, diam1}) + $signed({4'd0, diam2})
                     - $signed({{2{tolerance[TOL_W-1]}}, tolerance, 1'b0});
            u_sq_in  = item_ff.u_mag * item_ff.u_mag;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            lim_pos_in = (lim_ff > 0);
            lsq_in     = lim_ff[LIM_W-2:0] * lim_ff[LIM_W-2:0];
            v_sq_in    = item_ff.v_mag * item_ff.v_mag;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (lim_pos_ff && (uv4 < UV4_W'(lsq_ff))) begin
               if (item_ff.w_pos) begin
                  shadow_in[item_ff.addr1] = 1'b1;
               end else begin
                  shadow_in[item_ff.addr2] = 1'b1;
               end
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         shadow_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shadow_ff    <= shadow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff       <= item_in;
      lim_ff        <= lim_in;
      u_sq_ff       <= u_sq_in;
      v_sq_ff       <= v_sq_in;
      lsq_ff        <= lsq_in;
      lim_pos_ff    <= lim_pos_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_first_shadowed  = rsp_first_ff;
   assign rsp_second_shadowed = rsp_second_ff;
   assign rsp_row_flag        = rsp_first_ff | rsp_second_ff;

endmodule

// ----- hdl/baseline_shadow_flagger.sv -----
// Baseline shadow flagger, top level. A query beat passes through the queue and the back
// end into the registered response. The back end takes one beat at a time; a live row
// steps through table read, limit, square and compare; loads, queries and skipped rows finish in the idle state.
// Reset is synchronous, active high: clears tolerance, shadow bitmap, queue and response
// register at once; the diameter table keeps its contents and must be loaded before use.
// Depends on bsf_pkg, bsf_front, bsf_queue, bsf_back, bsf_ram.
module baseline_shadow_flagger import bsf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_write_enable,
   input  logic [TOL_W-1:0]   csr_write_data,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic               req_new_timestep,
   input  logic [ANT_W-1:0]   req_first_antenna,
   input  logic [ANT_W-1:0]   req_second_antenna,
   input  logic [COORD_W-1:0] req_u_component,
   input  logic [COORD_W-1:0] req_v_component,
   input  logic [COORD_W-1:0] req_w_component,
   input  logic [DIAM_W-1:0]  req_dish_diameter,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_row_flag,
   output logic               rsp_first_shadowed,
   output logic               rsp_second_shadowed
);

   // Tolerance register; to be written only while the block is idle; the block does not enforce this.
   logic [TOL_W-1:0] tolerance_ff, tolerance_in;

   item_type         push_item, head_item;
   queue_status_type queue_status;
   logic             push, pop;

   assign tolerance_in = csr_write_enable ? csr_write_data : tolerance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= '0;
      end else begin
         tolerance_ff <= tolerance_in;
      end
   end

   // Front end: decode and drop no-op beats (unused mode, load past the table).
   bsf_front u_front (
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_new_timestep   (req_new_timestep),
      .req_first_antenna  (req_first_antenna),
      .req_second_antenna (req_second_antenna),
      .req_u_component    (req_u_component),
      .req_v_component    (req_v_component),
      .req_w_component    (req_w_component),
      .req_dish_diameter  (req_dish_diameter),
      .queue_status       (queue_status),
      .push               (push),
      .push_item          (push_item)
   );

   // Decoupling queue: the front keeps taking beats while a row is in the back end, until the queue is full.
   bsf_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_item    (push_item),
      .pop          (pop),
      .head_item    (head_item),
      .queue_status (queue_status)
   );

   // Back end: one beat at a time, so bitmap and table updates land before the next.
   bsf_back u_back (
      .clock               (clock),
      .reset               (reset),
      .tolerance           (tolerance_ff),
      .head_item           (head_item),
      .queue_status        (queue_status),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_row_flag        (rsp_row_flag),
      .rsp_first_shadowed  (rsp_first_shadowed),
      .rsp_second_shadowed (rsp_second_shadowed)
   );

endmodule

// ----- dv/baseline_shadow_flagger_test.sv -----
// Self-checking testbench for baseline_shadow_flagger: directed beats, then random timesteps.
// Keeps its own shadow predictor and checks every response beat in order.
// Depends on bsf_pkg and the baseline_shadow_flagger RTL.
module baseline_shadow_flagger_test;
   import bsf_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int POOL_SPAN = 12;     // antennas per simulated timestep
   localparam int SETTLE_CYCLES = 16; // a skipped response leaves rows in flight
   localparam int SQUEEZE_CYCLES = 80;

   typedef struct {
      logic [MODE_W-1:0]  mode;
      logic               new_ts;
      logic [ANT_W-1:0]   ant1;
      logic [ANT_W-1:0]   ant2;
      logic [COORD_W-1:0] u;
      logic [COORD_W-1:0] v;
      logic [COORD_W-1:0] w;
      logic [DIAM_W-1:0]  diam;
   } req_beat_type;

   typedef struct packed {
      logic row_flag;
      logic first_shadowed;
      logic second_shadowed;
   } flag_set_type;

   typedef struct {
      req_beat_type beat;
      bit           typed;   // want holds a hand-written answer
      flag_set_type want;
   } directed_entry_type;

   localparam flag_set_type NO_SHADOW = '0;

   logic               clock;
   logic               reset;
   logic               csr_write_enable;
   logic [TOL_W-1:0]   csr_write_data;
   logic               req_valid;
   logic               req_stall;
   logic [MODE_W-1:0]  req_mode;
   logic               req_new_timestep;
   logic [ANT_W-1:0]   req_first_antenna;
   logic [ANT_W-1:0]   req_second_antenna;
   logic [COORD_W-1:0] req_u_component;
   logic [COORD_W-1:0] req_v_component;
   logic [COORD_W-1:0] req_w_component;
   logic [DIAM_W-1:0]  req_dish_diameter;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_row_flag;
   logic               rsp_first_shadowed;
   logic               rsp_second_shadowed;

   // Predictor state: diameters, which entries were loaded, shadow bits, tolerance.
   logic [DIAM_W-1:0]       dish_mm [NUM_ANTENNAS];
   bit                      dish_loaded [NUM_ANTENNAS];
   bit                      shadowed [NUM_ANTENNAS];
   logic signed [TOL_W-1:0] tolerance_mm;

   flag_set_type       pending_flags[$];  // expected query answers, oldest first
   directed_entry_type directed_beats[$];
   int                 mismatch_count;
   int                 beats_sent;        // beats that the block acts on
   bit                 quiet_mode;        // no idling on either side
   bit                 squeeze_request;   // ask the receiver for one long hold-off

   baseline_shadow_flagger DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_new_timestep    (req_new_timestep),
      .req_first_antenna   (req_first_antenna),
      .req_second_antenna  (req_second_antenna),
      .req_u_component     (req_u_component),
      .req_v_component     (req_v_component),
      .req_w_component     (req_w_component),
      .req_dish_diameter   (req_dish_diameter),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_row_flag        (rsp_row_flag),
      .rsp_first_shadowed  (rsp_first_shadowed),
      .rsp_second_shadowed (rsp_second_shadowed)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Hard stop well beyond the slowest legal run.
   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
   endtask

   function automatic req_beat_type beat_of(input logic [MODE_W-1:0] mode, input bit new_ts,
                                            input int ant1, input int ant2, input int u,
                                            input int v, input int w, input int diam);
      req_beat_type b;
      b.mode   = mode;
      b.new_ts = new_ts;
      b.ant1   = ANT_W'(ant1);
      b.ant2   = ANT_W'(ant2);
      b.u      = COORD_W'(u);
      b.v      = COORD_W'(v);
      b.w      = COORD_W'(w);
      b.diam   = DIAM_W'(diam);
      return b;
   endfunction

   // Append one row to the directed table.
   function automatic void add_directed(input directed_entry_type e);
      directed_beats.insert(directed_beats.size(), e);
   endfunction

   // S = d1 + d2 - 2*tolerance; the pair shadows when S > 0 and 4*(u^2+v^2) < S^2.
   function automatic longint shadow_span(input int ant1, input int ant2);
      return longint'(dish_mm[ant1]) + longint'(dish_mm[ant2]) - 2 * longint'(tolerance_mm);
   endfunction

   // Advance the predictor by one accepted beat; queue the answer of a query.
   function automatic void update_shadow_state(input req_beat_type b, input bit typed,
                                               input flag_set_type want);
      int           a1;
      int           a2;
      bit           ok1;
      bit           ok2;
      longint       span;
      longint       us;
      longint       vs;
      logic [63:0]  um;
      logic [63:0]  vm;
      logic [65:0]  uv4;
      logic [65:0]  span_sq;
      flag_set_type flags;
      a1  = int'(b.ant1);
      a2  = int'(b.ant2);
      ok1 = a1 < NUM_ANTENNAS;
      ok2 = a2 < NUM_ANTENNAS;
      case (b.mode)
         MODE_LOAD: begin
            if (ok1) begin
               dish_mm[a1]     = b.diam;
               dish_loaded[a1] = 1'b1;
            end
         end
         MODE_ROW: begin
            // the clear happens even when the row itself is skipped
            if (b.new_ts) begin
               foreach (shadowed[i]) shadowed[i] = 1'b0;
            end
            if (ok1 && ok2 && a1 != a2) begin
               span = shadow_span(a1, a2);
               if (span > 0) begin
                  us      = longint'($signed(b.u));
                  vs      = longint'($signed(b.v));
                  um      = (us < 0) ? -us : us;
                  vm      = (vs < 0) ? -vs : vs;
                  uv4     = um * um;
                  uv4     = (uv4 + vm * vm) << 2;
                  span_sq = span * span;
                  if (uv4 < span_sq) begin
                     if ($signed(b.w) > 0) shadowed[a1] = 1'b1;
                     else shadowed[a2] = 1'b1;
                  end
               end
            end
         end
         MODE_QUERY: begin
            flags.first_shadowed  = ok1 ? shadowed[a1] : 1'b0;
            flags.second_shadowed = ok2 ? shadowed[a2] : 1'b0;
            flags.row_flag        = flags.first_shadowed | flags.second_shadowed;
            pending_flags.insert(pending_flags.size(), typed ? want : flags);
         end
         default: ;  // unused mode: ignored
      endcase
   endfunction

   // Offer one beat, with random idle cycles ahead of it, and hold it until taken.
   task automatic send_beat(input req_beat_type b, input bit typed, input flag_set_type want);
      while (!quiet_mode && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_mode           <= b.mode;
      req_new_timestep   <= b.new_ts;
      req_first_antenna  <= b.ant1;
      req_second_antenna <= b.ant2;
      req_u_component    <= b.u;
      req_v_component    <= b.v;
      req_w_component    <= b.w;
      req_dish_diameter  <= b.diam;
      do @(posedge clock); while (req_stall);
      update_shadow_state(b, typed, want);
      if (b.mode != MODE_UNUSED) beats_sent++;
   endtask

   function automatic int pick_diameter();
      if ($urandom_range(0, 99) < 85) return $urandom_range(500, 60000);
      return int'($urandom());
   endfunction

   function automatic int coord_within(input int reach);
      return int'($urandom_range(0, 2 * reach)) - reach;
   endfunction

   function automatic int pick_w();
      case ($urandom_range(0, 9))
         0, 1:    return 0;
         2:       return int'($urandom());
         3, 4, 5: return -int'($urandom_range(1, 1000000));
         default: return int'($urandom_range(1, 1000000));
      endcase
   endfunction

   // A row may only touch table entries that were loaded before.
   task automatic ensure_loaded(input int ant);
      if (!dish_loaded[ant]) begin
         send_beat(beat_of(MODE_LOAD, $urandom_range(0, 1), ant, $urandom_range(0, 255),
                           int'($urandom()), int'($urandom()), int'($urandom()),
                           pick_diameter()), 1'b0, NO_SHADOW);
      end
   endtask

   // Well-formed baseline inside the current pool, aimed near the shadow circle.
   task automatic send_pool_row(input int base, input bit new_ts);
      int     a1;
      int     a2;
      int     u;
      int     v;
      int     half;
      longint span;
      a1 = base + $urandom_range(0, POOL_SPAN - 1);
      a2 = base + $urandom_range(0, POOL_SPAN - 1);
      if ($urandom_range(0, 99) < 5) a2 = a1;
      if (a1 != a2) begin
         ensure_loaded(a1);
         ensure_loaded(a2);
      end
      span = (a1 != a2) ? shadow_span(a1, a2) : 0;
      if (span > 0) begin
         half = int'(span / 2);
         if ($urandom_range(0, 99) < 30) begin
            // straddle the edge of the circle along one axis
            u = half + $urandom_range(0, 1);
            if ($urandom_range(0, 1)) u = -u;
            v = 0;
            if ($urandom_range(0, 1)) begin
               v = u;
               u = 0;
            end
         end else begin
            u = coord_within(half * 3 / 4 + 1);
            v = coord_within(half * 3 / 4 + 1);
         end
      end else begin
         u = coord_within(100000);
         v = coord_within(100000);
      end
      send_beat(beat_of(MODE_ROW, new_ts, a1, a2, u, v, pick_w(), int'($urandom())),
                1'b0, NO_SHADOW);
   endtask

   // Row anywhere with fully random coordinates; mostly far outside any shadow.
   task automatic send_wild_row();
      int a1;
      int a2;
      a1 = $urandom_range(0, NUM_ANTENNAS - 1);
      a2 = $urandom_range(0, NUM_ANTENNAS - 1);
      if (a1 != a2) begin
         ensure_loaded(a1);
         ensure_loaded(a2);
      end
      send_beat(beat_of(MODE_ROW, $urandom_range(0, 1), a1, a2, int'($urandom()),
                        int'($urandom()), int'($urandom()), int'($urandom())),
                1'b0, NO_SHADOW);
   endtask

   task automatic send_query(input int base);
      int a1;
      int a2;
      a1 = base + $urandom_range(0, POOL_SPAN - 1);
      a2 = base + $urandom_range(0, POOL_SPAN - 1);
      if ($urandom_range(0, 9) == 0) a2 = $urandom_range(0, NUM_ANTENNAS - 1);
      send_beat(beat_of(MODE_QUERY, $urandom_range(0, 1), a1, a2, int'($urandom()),
                        int'($urandom()), int'($urandom()), int'($urandom())),
                1'b0, NO_SHADOW);
   endtask

   // Timesteps: an opening row that clears the bitmap, a burst of rows mixed with
   // reloads, noise and stray clears, then queries over the same antenna pool.
   task automatic run_timesteps(input int quota);
      int stop_at;
      int base;
      int pick;
      stop_at = beats_sent + quota;
      while (beats_sent < stop_at) begin
         base = $urandom_range(0, NUM_ANTENNAS - POOL_SPAN);
         send_pool_row(base, 1'b1);
         repeat ($urandom_range(1, 7)) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               send_wild_row();
            end else if (pick < 18) begin
               send_beat(beat_of(MODE_LOAD, $urandom_range(0, 1),
                                 base + $urandom_range(0, POOL_SPAN - 1), 0, 0, 0, 0,
                                 pick_diameter()), 1'b0, NO_SHADOW);
            end else if (pick < 21) begin
               send_beat(beat_of(MODE_UNUSED, $urandom_range(0, 1), $urandom_range(0, 255),
                                 $urandom_range(0, 255), int'($urandom()), int'($urandom()),
                                 int'($urandom()), int'($urandom())), 1'b0, NO_SHADOW);
            end else begin
               send_pool_row(base, pick < 25);
            end
         end
         repeat ($urandom_range(1, 6)) send_query(base);
      end
   endtask

   // Register writes only once the block has drained.
   task automatic write_tolerance(input int value);
      req_valid <= 1'b0;
      while (pending_flags.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= TOL_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tolerance_mm = TOL_W'(value);
   endtask

   // Receiver: random stalls, a quiet stretch, and one long hold-off on request.
   initial begin : rsp_driver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (squeeze_request) begin
            squeeze_request = 1'b0;
            hold_left       = SQUEEZE_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (quiet_mode) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 9);
         end
      end
   end

   // Response checker: every accepted beat against the oldest expectation.
   always @(posedge clock) begin : rsp_check
      flag_set_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_flags.size() == 0) begin
            report_mismatch("response beat with nothing pending", 1, 0);
         end else begin
            want = pending_flags.pop_front();
            if (rsp_row_flag !== want.row_flag)
               report_mismatch("row_flag", rsp_row_flag, want.row_flag);
            if (rsp_first_shadowed !== want.first_shadowed)
               report_mismatch("first_shadowed", rsp_first_shadowed, want.first_shadowed);
            if (rsp_second_shadowed !== want.second_shadowed)
               report_mismatch("second_shadowed", rsp_second_shadowed, want.second_shadowed);
         end
      end
   end

   initial begin : main_sequence
      int tol_steps[5];
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      req_valid          = 1'b0;
      req_mode           = MODE_LOAD;
      req_new_timestep   = 1'b0;
      req_first_antenna  = '0;
      req_second_antenna = '0;
      req_u_component    = '0;
      req_v_component    = '0;
      req_w_component    = '0;
      req_dish_diameter  = '0;
      rsp_stall          = 1'b0;
      quiet_mode         = 1'b0;
      squeeze_request    = 1'b0;
      mismatch_count     = 0;
      beats_sent         = 0;
      tolerance_mm       = '0;
      foreach (shadowed[i]) begin
         shadowed[i]    = 1'b0;
         dish_loaded[i] = 1'b0;
         dish_mm[i]     = '0;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed beats at tolerance 0. Typed answers: bitmap empty after reset,
      // after a clear, and for a pair whose limit is zero.
      add_directed('{beat_of(MODE_QUERY, 0, 0, 1, 0, 0, 0, 0), 1'b1, NO_SHADOW});
      add_directed('{beat_of(MODE_QUERY, 1, 255, 128, -1, -1, -1, 1048575), 1'b1, NO_SHADOW});
      add_directed('{beat_of(MODE_LOAD, 0, 0, 0, 0, 0, 0, 1000), 1'b0, NO_SHADOW});
      add_directed('{beat_of(MODE_LOAD, 0, 1, 0, 0, 0, 0, 1000), 1'b0, NO_SHADOW});
      // max diameter, new_timestep set on a load (ignored)
      add_directed('{beat_of(MODE_LOAD, 1, 255, 255, 0, 0, 0, 1048575), 1'b0, NO_SHADOW});
      add_directed('{beat_of(MODE_LOAD, 0, 254, 0, 0, 0, 0, 0), 1'b0, NO_SHADOW});
      add_directed('{beat_of(MODE_LOAD, 0, 2, 0, 0, 0, 0, 0), 1'b0, NO_SHADOW});
      // just inside the circle, w>0: first antenna marked
      add_directed('{beat_of(MODE_ROW, 1, 0, 1, 999, 0, 1, 0), 1'b0, NO_SHADOW});
      add_directed('{beat_of(MODE_QUERY, 0, 0, 1, 0, 0, 0, 0), 1'b0, NO_SHADOW});
      // exactly on the circle: no mark
      add_directed('{beat_of(MODE_ROW, 0, 0, 1, 1000, 0, -5, 0), 1'b0, NO_SHADOW});
      // w = 0 marks the second antenna
      add_directed('{beat_of(MODE_ROW, 0, 0, 1, 0, -999, 0, 0), 1'b0, NO_SHADOW});
      add_directed('{beat_of(MODE_QUERY, 0, 1, 0, 0, 0, 0, 0), 1'b0, NO_SHADOW});
      // autocorrelation row: skipped, but its clear still wipes the bitmap
      add_directed('{beat_of(MODE_ROW, 1, 255, 255, 0, 0, 1, 0), 1'b0, NO_SHADOW});
      add_directed('{beat_of(MODE_QUERY, 0, 0, 1, 0, 0, 0, 0), 1'b1, NO_SHADOW});
      // zero limit: nothing marked even at the origin
      add_directed('{beat_of(MODE_ROW, 0, 254, 2, 0, 0, 1, 0), 1'b0, NO_SHADOW});
      add_directed('{beat_of(MODE_QUERY, 0, 254, 2, 0, 0, 0, 0), 1'b1, NO_SHADOW});
      // coordinate extremes, far outside
      add_directed('{beat_of(MODE_ROW, 0, 255, 254, -1073741824, -1073741824,
                             1073741823, 0), 1'b0, NO_SHADOW});
      add_directed('{beat_of(MODE_ROW, 0, 255, 254, 1073741823, 1073741823,
                             -1073741824, 1048575), 1'b0, NO_SHADOW});
      // unused mode: ignored entirely
      add_directed('{beat_of(MODE_UNUSED, 1, 255, 255, -1, -1, -1, 1048575), 1'b0, NO_SHADOW});
      add_directed('{beat_of(MODE_ROW, 0, 255, 254, 0, 0, -1073741823, 0), 1'b0, NO_SHADOW});
      // new_timestep on a query is ignored
      add_directed('{beat_of(MODE_QUERY, 1, 254, 255, 0, 0, 0, 0), 1'b0, NO_SHADOW});
      // odd limit, largest radius still inside: first antenna marked too
      add_directed('{beat_of(MODE_ROW, 0, 255, 254, 524287, 0, 1, 0), 1'b0, NO_SHADOW});
      add_directed('{beat_of(MODE_QUERY, 0, 255, 254, 0, 0, 0, 0), 1'b0, NO_SHADOW});

      foreach (directed_beats[i]) begin
         send_beat(directed_beats[i].beat, directed_beats[i].typed, directed_beats[i].want);
      end

      // Tolerance extremes first, then ordinary settings. Phase 2 runs without any
      // idling; phase 3 opens with a long receiver hold-off so the request side backs up.
      tol_steps[0] = -1048576;
      tol_steps[1] = 1048575;
      tol_steps[2] = 2000;
      tol_steps[3] = int'($urandom_range(0, 8000)) - 4000;
      tol_steps[4] = 0;
      foreach (tol_steps[p]) begin
         write_tolerance(tol_steps[p]);
         quiet_mode = (p == 2);
         if (p == 3) squeeze_request = 1'b1;
         run_timesteps(100);
      end
      quiet_mode = 1'b0;
      req_valid <= 1'b0;

      while (pending_flags.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
